// ----- design/nvs_pkg.sv -----
// shared types and constants for the nearest value search block
package nvs_pkg;

   // field widths
   localparam int IDX_W    = 6;
   localparam int DATA_W   = 32;
   localparam int IDX_SPAN = 2 ** IDX_W;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   // register port widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [IDX_W-1:0] RANGE_LOW_RESET  = 6'd0;
   localparam logic [IDX_W-1:0] RANGE_HIGH_RESET = 6'd63;

   // request kinds carried on tuser
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } nvs_req_kind_type;

   // register indexes
   typedef enum logic {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } nvs_csr_index_type;

   // search token handed from stage to stage
   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic                     bad;
      logic signed [DATA_W-1:0] target;
      logic        [IDX_W-1:0]  i;
      logic        [IDX_W-1:0]  j;
      logic        [IDX_W-1:0]  mid;
      logic        [IDX_W-1:0]  k;
      logic signed [DATA_W-1:0] value;
   } nvs_token_type;

endpackage

// ----- design/nvs_ram.sv -----
// generic single write, dual registered read ram
module nvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- design/nvs_head.sv -----
// query entry stage: range checks against the range low and high entries
module nvs_head (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              query_accept,
   input  logic signed [nvs_pkg::DATA_W-1:0] query_target,
   input  logic        [nvs_pkg::IDX_W-1:0]  range_lo,
   input  logic        [nvs_pkg::IDX_W-1:0]  range_hi,
   input  logic                              range_bad,
   input  logic signed [nvs_pkg::DATA_W-1:0] lo_value,
   input  logic signed [nvs_pkg::DATA_W-1:0] hi_value,
   output nvs_pkg::nvs_token_type            tok_out
);
   import nvs_pkg::*;

   logic                     q_valid_ff;
   logic                     q_valid_in;
   logic signed [DATA_W-1:0] q_target_ff;
   logic signed [DATA_W-1:0] t;

   assign q_valid_in = query_accept;
   assign t          = q_target_ff;

   // query holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (query_accept) begin
         q_target_ff <= query_target;
      end
   end

   // bad range and end checks, else open the search over the whole range
   always_comb begin
      tok_out.valid  = q_valid_ff;
      tok_out.bad    = range_bad;
      tok_out.target = q_target_ff;
      tok_out.i      = range_lo;
      tok_out.j      = range_hi;
      tok_out.mid    = IDX_W'(({1'b0, range_lo} + {1'b0, range_hi}) >> 1);
      tok_out.done   = 1'b1;
      tok_out.k      = '0;
      tok_out.value  = '0;
      if (range_bad) begin
         tok_out.k     = '0;
         tok_out.value = '0;
      end else if (t <= lo_value) begin
         tok_out.k     = range_lo;
         tok_out.value = lo_value;
      end else if (t >= hi_value) begin
         tok_out.k     = range_hi;
         tok_out.value = hi_value;
      end else begin
         tok_out.done = 1'b0;
      end
   end

endmodule

// ----- design/nvs_cell.sv -----
// one binary search step: narrows the window or settles on a neighbor pair
module nvs_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic        [nvs_pkg::IDX_W-1:0]  range_lo,
   input  logic        [nvs_pkg::IDX_W-1:0]  range_hi,
   input  logic signed [nvs_pkg::DATA_W-1:0] mid_value,
   input  logic signed [nvs_pkg::DATA_W-1:0] below_value,
   input  logic signed [nvs_pkg::DATA_W-1:0] above_value,
   input  nvs_pkg::nvs_token_type            tok_in,
   output nvs_pkg::nvs_token_type            tok_out
);
   import nvs_pkg::*;

   nvs_token_type            tok_ff;
   logic signed [DATA_W-1:0] t;
   logic                     go_up;
   logic                     near_pair;
   logic        [IDX_W-1:0]  a_idx;
   logic        [IDX_W-1:0]  b_idx;
   logic signed [DATA_W-1:0] a_val;
   logic signed [DATA_W-1:0] b_val;
   logic signed [DATA_W:0]   a_diff;
   logic signed [DATA_W:0]   b_diff;
   logic        [DATA_W:0]   a_dist;
   logic        [DATA_W:0]   b_dist;
   logic                     take_b;

   // token register, handed on every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign t     = tok_ff.target;
   assign go_up = !(t < mid_value);

   // neighbor pair around the probe
   always_comb begin
      if (go_up) begin
         a_idx = tok_ff.mid;
         a_val = mid_value;
         b_idx = tok_ff.mid + 1'b1;
         b_val = above_value;
      end else begin
         a_idx = tok_ff.mid - 1'b1;
         a_val = below_value;
         b_idx = tok_ff.mid;
         b_val = mid_value;
      end
   end

   assign near_pair = go_up ? ((tok_ff.mid < range_hi) && (t < above_value))
                            : ((tok_ff.mid > range_lo) && (t > below_value));

   // 33-bit distances, ties to the lower value then the lower index
   assign a_diff = $signed({t[DATA_W-1], t}) - $signed({a_val[DATA_W-1], a_val});
   assign b_diff = $signed({t[DATA_W-1], t}) - $signed({b_val[DATA_W-1], b_val});
   assign a_dist = a_diff[DATA_W] ? $unsigned(-a_diff) : $unsigned(a_diff);
   assign b_dist = b_diff[DATA_W] ? $unsigned(-b_diff) : $unsigned(b_diff);

   always_comb begin
      if (a_dist < b_dist) begin
         take_b = 1'b0;
      end else if (b_dist < a_dist) begin
         take_b = 1'b1;
      end else if (a_val < b_val) begin
         take_b = 1'b0;
      end else if (b_val < a_val) begin
         take_b = 1'b1;
      end else begin
         take_b = 1'b0;
      end
   end

   // search step
   always_comb begin
      tok_out = tok_ff;
      if (tok_ff.valid && !tok_ff.done) begin
         if (mid_value == t) begin
            tok_out.done  = 1'b1;
            tok_out.k     = tok_ff.mid;
            tok_out.value = mid_value;
         end else if (near_pair) begin
            tok_out.done  = 1'b1;
            tok_out.k     = take_b ? b_idx : a_idx;
            tok_out.value = take_b ? b_val : a_val;
         end else begin
            if (go_up) begin
               tok_out.i = tok_ff.mid + 1'b1;
            end else begin
               tok_out.j = tok_ff.mid;
            end
            // window closed: the last probe is the answer
            if (tok_out.i >= tok_out.j) begin
               tok_out.done  = 1'b1;
               tok_out.k     = tok_ff.mid;
               tok_out.value = mid_value;
            end
         end
         tok_out.mid = IDX_W'(({1'b0, tok_out.i} + {1'b0, tok_out.j}) >> 1);
      end
   end

endmodule

// ----- design/nearest_value_search_core.sv -----
// nearest value search core: table ram, search cell chain, stream and register ports
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+---------------------------------------
//  req_*    | in  | tvalid / tready            | tuser kind, tdata index/value/target
//  rsp_*    | out | tvalid / tready            | tdata value/index, tuser bad range
//  csr_*    | in  | psel/penable/pwrite/pready | range_low at 0x0, range_high at 0x4
//
//  a write request goes into both ram copies; a query passes the head register, the
//  register of each cell and the result and output registers up to rsp_tvalid, with
//  NUM_CELLS = log2(min(TABLE_DEPTH, 64)), one search step per cell; each step reads
//  the probe and both neighbors from two ram copies; one query is in the chain at a
//  time; the next request is taken as the result moves to the output register, so a
//  held rsp stalls at most one finished result; reset sets range_low to 0 and
//  range_high to 63; table contents are undefined until written and get no clearing pass
module nearest_value_search_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nvs_pkg::REQ_TDATA_W-1:0]    req_tdata,  // entry_index, entry_value, target
   input  logic                               req_tuser,  // req_type
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nvs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // nearest_value, nearest_index
   output logic                               rsp_tuser,  // bad_range
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nvs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nvs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nvs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import nvs_pkg::*;

   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int SEARCH_SPAN = (TABLE_DEPTH < IDX_SPAN) ? TABLE_DEPTH : IDX_SPAN;
   localparam int NUM_CELLS   = $clog2(SEARCH_SPAN);
   localparam int LAST_INDEX  = TABLE_DEPTH - 1;
   localparam int RSP_PAD     = RSP_TDATA_W - DATA_W - IDX_W;

   // request fields
   logic             [IDX_W-1:0]  req_entry_index;
   logic signed      [DATA_W-1:0] req_entry_value;
   logic signed      [DATA_W-1:0] req_target;
   nvs_req_kind_type              req_kind;
   logic                          req_accept;
   logic                          query_accept;
   logic                          table_wr;

   // configuration
   logic [IDX_W-1:0]  range_low_ff;
   logic [IDX_W-1:0]  range_high_ff;
   logic [IDX_W-1:0]  lo_c;
   logic [IDX_W-1:0]  hi_c;
   logic              range_bad;
   logic              csr_wr;
   nvs_csr_index_type csr_index;

   // search chain
   nvs_token_type            stage_tok [NUM_CELLS+1];
   logic [NUM_CELLS:0]       stage_valid;
   logic [IDX_W-1:0]         probe_mid;
   logic [IDX_W-1:0]         rd_mid;
   logic [DATA_W-1:0]        mid_word;
   logic [DATA_W-1:0]        below_word;
   logic [DATA_W-1:0]        above_word;
   logic [DATA_W-1:0]        hi_word;
   logic signed [DATA_W-1:0] mid_value;
   logic signed [DATA_W-1:0] below_value;
   logic signed [DATA_W-1:0] above_value;
   logic signed [DATA_W-1:0] hi_value;

   // result and output registers
   nvs_token_type            res_ff;
   nvs_token_type            res_in;
   logic                     res_move;
   logic                     busy;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic        [IDX_W-1:0]  rsp_index_ff;
   logic                     rsp_bad_ff;

   // request unpack
   assign req_entry_index = req_tdata[IDX_W-1:0];
   assign req_entry_value = req_tdata[IDX_W+DATA_W-1:IDX_W];
   assign req_target      = req_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
   assign req_kind        = nvs_req_kind_type'(req_tuser);

   assign req_accept   = req_tvalid && req_tready;
   assign query_accept = req_accept && (req_kind == REQ_QUERY);
   assign table_wr     = req_accept && (req_kind == REQ_WRITE)
                         && (int'(req_entry_index) < TABLE_DEPTH);

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = nvs_csr_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_pwdata[IDX_W-1:0];
            CSR_RANGE_HIGH: range_high_ff <= csr_pwdata[IDX_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_RANGE_LOW:  csr_prdata = CSR_DATA_W'(range_low_ff);
         CSR_RANGE_HIGH: csr_prdata = CSR_DATA_W'(range_high_ff);
      endcase
   end

   // range limits saturated to the table
   assign lo_c = (int'(range_low_ff) > LAST_INDEX) ? IDX_W'(LAST_INDEX) : range_low_ff;
   assign hi_c = (int'(range_high_ff) > LAST_INDEX) ? IDX_W'(LAST_INDEX) : range_high_ff;
   assign range_bad = lo_c > hi_c;

   // probe address from the stage holding the query, else the range low end
   always_comb begin
      probe_mid = '0;
      for (int s = 0; s < NUM_CELLS; s++) begin
         probe_mid = probe_mid | (stage_tok[s].mid & {IDX_W{stage_tok[s].valid}});
      end
      rd_mid = (|stage_valid[NUM_CELLS-1:0]) ? probe_mid : lo_c;
   end

   // two table copies: probe and lower neighbor, upper neighbor and range high end
   nvs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (table_wr),
      .wr_addr   (AW'(req_entry_index)),
      .wr_data   (req_entry_value),
      .rd_addr_a (AW'(rd_mid)),
      .rd_data_a (mid_word),
      .rd_addr_b (AW'(rd_mid - 1'b1)),
      .rd_data_b (below_word)
   );

   nvs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (table_wr),
      .wr_addr   (AW'(req_entry_index)),
      .wr_data   (req_entry_value),
      .rd_addr_a (AW'(rd_mid + 1'b1)),
      .rd_data_a (above_word),
      .rd_addr_b (AW'(hi_c)),
      .rd_data_b (hi_word)
   );

   assign mid_value   = $signed(mid_word);
   assign below_value = $signed(below_word);
   assign above_value = $signed(above_word);
   assign hi_value    = $signed(hi_word);

   // entry stage; the idle probe address has just read the range low entry
   nvs_head u_head (
      .clock        (clock),
      .reset        (reset),
      .query_accept (query_accept),
      .query_target (req_target),
      .range_lo     (lo_c),
      .range_hi     (hi_c),
      .range_bad    (range_bad),
      .lo_value     (mid_value),
      .hi_value     (hi_value),
      .tok_out      (stage_tok[0])
   );

   // chain of search cells
   for (genvar s = 0; s < NUM_CELLS; s++) begin : g_cell
      nvs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .range_lo    (lo_c),
         .range_hi    (hi_c),
         .mid_value   (mid_value),
         .below_value (below_value),
         .above_value (above_value),
         .tok_in      (stage_tok[s]),
         .tok_out     (stage_tok[s+1])
      );
   end

   for (genvar s = 0; s <= NUM_CELLS; s++) begin : g_valid
      assign stage_valid[s] = stage_tok[s].valid;
   end

   // finished query waits here for the output register
   assign res_move = res_ff.valid && (!rsp_valid_ff || rsp_tready);
   assign busy     = (|stage_valid) || (res_ff.valid && !res_move);
   assign req_tready = !busy;

   always_comb begin
      res_in = res_ff;
      if (res_move) begin
         res_in.valid = 1'b0;
      end
      if (stage_tok[NUM_CELLS].valid) begin
         res_in = stage_tok[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff <= res_in;
      end
   end

   // output register
   assign rsp_valid_in = res_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_move) begin
         rsp_value_ff <= res_ff.value;
         rsp_index_ff <= res_ff.k;
         rsp_bad_ff   <= res_ff.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_index_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_bad_ff;

   // at most one query anywhere between entry and result register
   a_single_query: assert property (@(posedge clock) disable iff (reset)
      $onehot0({stage_valid, res_ff.valid}))
      else $error("more than one query in the search chain");

   // the chain is deep enough to settle every query
   a_res_settled: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> res_ff.done)
      else $error("query left the last cell unsettled");

   // a bad range result carries zero index and value
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_index_ff == '0) && (rsp_value_ff == '0))
      else $error("bad range result with nonzero payload");

   // a good result points inside the searched range
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bad_ff) |-> (rsp_index_ff >= lo_c) && (rsp_index_ff <= hi_c))
      else $error("result index outside the search range");

endmodule

// ----- tb/tb_nearest_value_search_core.sv -----
// testbench for the nearest value search core: request driver, result checker and stimulus
module tb_nearest_value_search_core;
   timeunit 1ns;
   timeprecision 1ps;

   import nvs_pkg::*;

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_CYCLES = 12;

   // traffic shaping modes for the two stream sides
   typedef enum logic [1:0] {
      TRAFFIC_STEADY,
      TRAFFIC_SEND_IDLE,
      TRAFFIC_RECV_STALL,
      TRAFFIC_BOTH_IDLE
   } traffic_mode_type;

   // table fill patterns
   typedef enum logic [1:0] {
      FILL_SPREAD,
      FILL_DENSE
   } fill_mode_type;

   typedef struct {
      nvs_req_kind_type         kind;
      logic        [IDX_W-1:0]  index;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] target;
   } search_request_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic        [IDX_W-1:0]  index;
      logic                     bad;
   } nearest_result_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic                     req_tuser   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   traffic_mode_type         traffic      = TRAFFIC_STEADY;
   logic                     hold_request = 1'b0;
   logic                     hold_taken   = 1'b0;
   int                       hold_left    = 0;
   int                       fail_count   = 0;
   int                       queued_count = 0;

   search_request_type       pending_requests[$];
   nearest_result_type       nearest_expected[$];

   // predictor state: table and range registers as seen on the buses
   logic signed [DATA_W-1:0] entry_store[IDX_SPAN];
   logic        [IDX_W-1:0]  range_low_now  = RANGE_LOW_RESET;
   logic        [IDX_W-1:0]  range_high_now = RANGE_HIGH_RESET;

   // stimulus-side copy of the table and ranges, used to aim targets
   logic signed [DATA_W-1:0] shadow_table[IDX_SPAN];
   int                       gen_low  = int'(RANGE_LOW_RESET);
   int                       gen_high = int'(RANGE_HIGH_RESET);

   nearest_value_search_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic bit idle_roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // pick the closer of two entries, lower value then lower index on a tie
   function automatic int closer_entry(int a, int b, longint t);
      longint va, vb, da, db;
      va = longint'(entry_store[a]);
      vb = longint'(entry_store[b]);
      da = (t > va) ? t - va : va - t;
      db = (t > vb) ? t - vb : vb - t;
      if (da < db) return a;
      if (db < da) return b;
      if (va < vb) return a;
      if (vb < va) return b;
      return (a < b) ? a : b;
   endfunction

   // binary search for the entry nearest to t within lo..hi
   function automatic int nearest_entry(longint t, int lo, int hi);
      int i, j, mid;
      i   = lo;
      j   = hi;
      mid = lo;
      if (t <= entry_store[lo]) return lo;
      if (t >= entry_store[hi]) return hi;
      while (i < j) begin
         mid = (i + j) / 2;
         if (entry_store[mid] == t) return mid;
         if (t < entry_store[mid]) begin
            if (mid > lo && t > entry_store[mid-1]) return closer_entry(mid - 1, mid, t);
            j = mid;
         end else begin
            if (mid < hi && t < entry_store[mid+1]) return closer_entry(mid, mid + 1, t);
            i = mid + 1;
         end
      end
      return mid;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      search_request_type r;
      int                 pct;
      pct = (traffic == TRAFFIC_SEND_IDLE) ? 82 : (traffic == TRAFFIC_BOTH_IDLE) ? 7 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && !idle_roll(pct)) begin
            r = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, r.target, r.value, r.index};
            req_tuser  <= r.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off counted here
   always @(posedge clock) begin : drive_ready
      int pct;
      pct = (traffic == TRAFFIC_RECV_STALL) ? 82 : (traffic == TRAFFIC_BOTH_IDLE) ? 7 : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_roll(pct);
         end
      end
   end

   // monitor: track registers and table writes, predict on each accepted query, check each result
   always @(posedge clock) begin : watch_streams
      nearest_result_type want;
      int                 k;
      if (reset) begin
         range_low_now  = RANGE_LOW_RESET;
         range_high_now = RANGE_HIGH_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (nvs_csr_index_type'(csr_paddr[2]))
               CSR_RANGE_LOW:  range_low_now  = csr_pwdata[IDX_W-1:0];
               CSR_RANGE_HIGH: range_high_now = csr_pwdata[IDX_W-1:0];
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (nvs_req_kind_type'(req_tuser) == REQ_WRITE) begin
               entry_store[req_tdata[5:0]] = req_tdata[37:6];
            end else begin
               if (range_low_now > range_high_now) begin
                  want.value = '0;
                  want.index = '0;
                  want.bad   = 1'b1;
               end else begin
                  k = nearest_entry(longint'($signed(req_tdata[69:38])),
                                    int'(range_low_now), int'(range_high_now));
                  want.value = entry_store[k];
                  want.index = IDX_W'(k);
                  want.bad   = 1'b0;
               end
               nearest_expected.push_back(want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (nearest_expected.size() == 0) begin
               $error("result with nothing expected: nearest_value %0d nearest_index %0d",
                      $signed(rsp_tdata[31:0]), rsp_tdata[37:32]);
               fail_count++;
            end else begin
               want = nearest_expected.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  $error("nearest_value expected %0d got %0d", want.value,
                         $signed(rsp_tdata[31:0]));
                  fail_count++;
               end
               if (rsp_tdata[37:32] !== want.index) begin
                  $error("nearest_index expected %0d got %0d", want.index, rsp_tdata[37:32]);
                  fail_count++;
               end
               if (rsp_tuser !== want.bad) begin
                  $error("bad_range expected %0d got %0d", want.bad, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] to_word(longint x);
      if (x < longint'(WORD_MIN)) return WORD_MIN;
      if (x > longint'(WORD_MAX)) return WORD_MAX;
      return DATA_W'(x);
   endfunction

   function automatic void queue_write(int idx, logic signed [DATA_W-1:0] v);
      search_request_type r;
      r.kind   = REQ_WRITE;
      r.index  = IDX_W'(idx);
      r.value  = v;
      r.target = $urandom;
      shadow_table[idx] = v;
      pending_requests.push_back(r);
      queued_count++;
   endfunction

   function automatic void queue_query(logic signed [DATA_W-1:0] t);
      search_request_type r;
      r.kind   = REQ_QUERY;
      r.index  = IDX_W'($urandom);
      r.value  = $urandom;
      r.target = t;
      pending_requests.push_back(r);
      queued_count++;
   endfunction

   // aim a target at an interesting spot of the current range
   function automatic logic signed [DATA_W-1:0] aim_target();
      int     k;
      longint a, b;
      if (gen_low > gen_high) return $urandom;
      k = $urandom_range(gen_high, gen_low);
      case ($urandom_range(7))
         0: return shadow_table[k];
         1: return to_word(longint'(shadow_table[k]) + ($urandom_range(1) ? 1 : -1));
         2: begin
            if (k == gen_high) return shadow_table[k];
            a = longint'(shadow_table[k]);
            b = longint'(shadow_table[k+1]);
            return to_word(a + (b - a) / 2);
         end
         3: return to_word(longint'(shadow_table[gen_low]) - $urandom_range(3));
         4: return to_word(longint'(shadow_table[gen_high]) + $urandom_range(3));
         5: return WORD_MIN;
         6: return WORD_MAX;
         default: return $urandom;
      endcase
   endfunction

   // fill the whole table in ascending order
   function automatic void load_table(fill_mode_type mode);
      longint vals[IDX_SPAN];
      longint key;
      int     j;
      vals[0] = longint'($urandom_range(2000)) - 1000;
      for (int i = 0; i < IDX_SPAN; i++) begin
         if (mode == FILL_SPREAD) vals[i] = longint'(int'($urandom));
         else if (i > 0) vals[i] = vals[i-1] + $urandom_range(3);
      end
      for (int i = 1; i < IDX_SPAN; i++) begin
         key = vals[i];
         j   = i - 1;
         while (j >= 0 && vals[j] > key) begin
            vals[j+1] = vals[j];
            j--;
         end
         vals[j+1] = key;
      end
      for (int i = 0; i < IDX_SPAN; i++) queue_write(i, to_word(vals[i]));
   endfunction

   // keep the table sorted while changing one entry
   function automatic void update_sorted_entry();
      int     i;
      longint lo_v, hi_v;
      i    = $urandom_range(IDX_SPAN - 1);
      lo_v = (i > 0) ? longint'(shadow_table[i-1]) : longint'(WORD_MIN);
      hi_v = (i < IDX_SPAN - 1) ? longint'(shadow_table[i+1]) : longint'(WORD_MAX);
      if (hi_v < lo_v) queue_write(i, $urandom);
      else queue_write(i, to_word(lo_v + longint'($urandom) % (hi_v - lo_v + 1)));
   endfunction

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_tvalid || nearest_expected.size() != 0)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input nvs_csr_index_type sel, input int v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == CSR_RANGE_LOW) gen_low = v;
      else gen_high = v;
      @(negedge clock);
   endtask

   task automatic set_range(input int lo, input int hi);
      wait_quiet();
      write_csr(CSR_RANGE_LOW, lo);
      write_csr(CSR_RANGE_HIGH, hi);
   endtask

   // stimulus
   initial begin : stimulus
      int round;
      int base;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // known table: extremes at both ends, a duplicate pair in the middle, steps of ten
      for (int i = 0; i < IDX_SPAN; i++) begin
         if (i == 0) queue_write(i, WORD_MIN);
         else if (i == IDX_SPAN - 1) queue_write(i, WORD_MAX);
         else if (i == 33) queue_write(i, 0);
         else queue_write(i, (i - 32) * 10);
      end

      // directed queries on the reset range
      queue_query(WORD_MIN);
      queue_query(WORD_MIN + 1);
      queue_query(WORD_MAX);
      queue_query(WORD_MAX - 1);
      queue_query(0);
      queue_query(5);
      queue_query(15);
      queue_query(-305);
      queue_query(301);
      queue_query(1000);
      queue_query(-1000000);

      // single-entry ranges, a narrow range and an inverted one
      set_range(63, 63);
      queue_query(5);
      set_range(0, 0);
      queue_query(5);
      set_range(10, 20);
      queue_query(0);
      queue_query(-205);
      set_range(40, 5);
      queue_query(7);
      set_range(0, 63);

      // random rounds
      base  = queued_count;
      round = 0;
      while (queued_count - base < RANDOM_ITEMS || round <= 6) begin
         if (round == 6) begin
            // receiver holds off while the sender keeps offering
            traffic      <= TRAFFIC_STEADY;
            hold_request <= 1'b1;
            repeat (40) queue_query(aim_target());
         end else begin
            traffic <= traffic_mode_type'(round % 4);
            if ($urandom_range(99) < 30) begin
               case ($urandom_range(9))
                  0: set_range(0, 63);
                  1: set_range(63, 63);
                  2: set_range(0, 0);
                  3: set_range(63, 0);
                  4: set_range($urandom_range(63, 1), $urandom_range(62));
                  5: set_range(62, 63);
                  default: begin
                     gen_low = $urandom_range(63);
                     set_range(gen_low, $urandom_range(63, gen_low));
                  end
               endcase
            end
            if ($urandom_range(5) == 0)
               load_table($urandom_range(1) ? FILL_SPREAD : FILL_DENSE);
            repeat ($urandom_range(3)) update_sorted_entry();
            // occasional out-of-order value leaves the table unsorted
            if ($urandom_range(9) == 0) queue_write($urandom_range(IDX_SPAN - 1), $urandom);
            repeat ($urandom_range(16, 6)) queue_query(aim_target());
         end
         while (pending_requests.size() > 8) @(negedge clock);
         round++;
      end

      wait_quiet();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
